/* src/stw_pkg.sv */
// ============================================================================
// stw_pkg
// Shared types and widths for the target-sum sliding window search.
// ============================================================================
package stw_pkg;

    localparam int VAL_W = 32;
    localparam int SUM_W = 48;
    localparam int POS_W = 11;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last_item;
    } t_item;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] end_pos;
        logic             too_long;
    } t_result;

endpackage

/* src/stw_in_queue.sv */
// ============================================================================
// stw_in_queue
// Two-entry input queue that decouples item intake from the search engine.
// ============================================================================
module stw_in_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  stw_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output stw_pkg::t_item o_item,
    input  logic           i_pop
);
    import stw_pkg::*;

    t_item       r_slot [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        do_push;
    logic        do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* src/stw_engine.sv */
// ============================================================================
// stw_engine
// Window store, running sum and head/tail tracking; holds one result.
// ============================================================================
module stw_engine #(
    parameter int MAX_LEN = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [stw_pkg::SUM_W-1:0]    i_target,
    input  logic                         i_item_valid,
    input  stw_pkg::t_item               i_item,
    output logic                         o_item_pop,
    output logic                         o_res_valid,
    output stw_pkg::t_result             o_res,
    input  logic                         i_res_pop
);
    import stw_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int PW = $clog2(MAX_LEN + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TEST,
        S_SUB
    } t_state;

    t_state           r_state,    n_state;
    logic [SUM_W-1:0] r_sum,      n_sum;
    logic [PW-1:0]    r_head,     n_head;
    logic [PW-1:0]    r_tail,     n_tail;
    logic [PW-1:0]    r_cnt,      n_cnt;
    logic             r_reported, n_reported;
    logic             r_overflow, n_overflow;
    logic             r_last,     n_last;
    logic             r_out_valid, n_out_valid;
    t_result          r_out,      n_out;

    logic [VAL_W-1:0] r_store [MAX_LEN];
    logic [VAL_W-1:0] r_rdata;
    logic             mem_we;
    logic             do_clear;
    logic             take;
    logic             matched;

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign take        = (r_state == S_IDLE) && i_item_valid && !r_out_valid;
    assign o_item_pop  = take;

    // Window store: write at tail, registered read at head.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_tail[AW-1:0]] <= i_item.value;
        end
        r_rdata <= r_store[r_head[AW-1:0]];
    end

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_head      = r_head;
        n_tail      = r_tail;
        n_cnt       = r_cnt;
        n_reported  = r_reported;
        n_overflow  = r_overflow;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        do_clear    = 1'b0;
        matched     = 1'b0;
        if (i_res_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (take) begin
                    if (r_reported) begin
                        do_clear = i_item.last_item;
                    end else if (r_overflow || (r_tail == PW'(MAX_LEN))) begin
                        n_overflow = 1'b1;
                        if (i_item.last_item) begin
                            n_out_valid = 1'b1;
                            n_out       = '{found: 1'b0, start_pos: '0,
                                            end_pos: '0, too_long: 1'b1};
                            do_clear    = 1'b1;
                        end
                    end else begin
                        mem_we  = 1'b1;
                        n_sum   = r_sum + SUM_W'(i_item.value);
                        n_cnt   = r_cnt + PW'(1);
                        n_last  = i_item.last_item;
                        n_state = S_TEST;
                    end
                end
            end
            S_TEST: begin
                if ((r_sum > i_target) && (r_cnt != '0)) begin
                    // Drop the head value; its read is in flight now.
                    n_state = S_SUB;
                end else begin
                    matched = (r_sum == i_target) && (r_cnt != '0);
                    if (matched) begin
                        n_out_valid = 1'b1;
                        n_out       = '{found: 1'b1,
                                        start_pos: POS_W'(r_head + PW'(1)),
                                        end_pos: POS_W'(r_tail + PW'(1)),
                                        too_long: 1'b0};
                        n_reported  = 1'b1;
                    end else if (r_last) begin
                        n_out_valid = 1'b1;
                        n_out       = '{found: 1'b0, start_pos: '0,
                                        end_pos: '0, too_long: 1'b0};
                    end
                    n_tail   = r_tail + PW'(1);
                    do_clear = r_last;
                    n_state  = S_IDLE;
                end
            end
            S_SUB: begin
                n_sum   = r_sum - SUM_W'(r_rdata);
                n_head  = r_head + PW'(1);
                n_cnt   = r_cnt - PW'(1);
                n_state = S_TEST;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (do_clear) begin
            n_sum      = '0;
            n_head     = '0;
            n_tail     = '0;
            n_cnt      = '0;
            n_reported = 1'b0;
            n_overflow = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_cnt       <= '0;
            r_reported  <= 1'b0;
            r_overflow  <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_cnt       <= n_cnt;
            r_reported  <= n_reported;
            r_overflow  <= n_overflow;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

endmodule

/* src/subarray_target_sum_window.sv */
// ============================================================================
// subarray_target_sum_window
// Finds the first contiguous run of a sequence that sums to a target.
// ============================================================================
// Items enter a two-entry queue and are processed by the engine one at a
// time. Each item passes through the store write and sum update, then
// the compare; every value dropped from the window head adds a subtract
// step and another compare, since the subtract waits on the registered
// read of the window store. Each stored value is dropped at most once.
// The engine holds a single result; while it waits to be popped, the
// engine stops but the input queue still takes items. Positions are
// 1-based and reported as their low 11 bits.
module subarray_target_sum_window #(
    parameter int MAX_LEN = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [stw_pkg::VAL_W-1:0] i_value,
    input  logic                      i_last_item,
    output logic                      empty,
    input  logic                      pop,
    output logic                      o_found,
    output logic [stw_pkg::POS_W-1:0] o_start_pos,
    output logic [stw_pkg::POS_W-1:0] o_end_pos,
    output logic                      o_too_long,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [stw_pkg::SUM_W-1:0] i_cfg_data
);
    import stw_pkg::*;

    logic [SUM_W-1:0] r_target;
    t_item            in_item;
    t_item            q_item;
    logic             q_valid;
    logic             q_pop;
    logic             res_valid;
    t_result          res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_target <= i_cfg_data;
        end
    end

    assign in_item = '{value: i_value, last_item: i_last_item};

    stw_in_queue u_in_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    stw_engine #(
        .MAX_LEN (MAX_LEN)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_target     (r_target),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_item_pop   (q_pop),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_pop    (pop)
    );

    assign empty       = !res_valid;
    assign o_found     = res.found;
    assign o_start_pos = res.start_pos;
    assign o_end_pos   = res.end_pos;
    assign o_too_long  = res.too_long;

    a_found_not_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_found) |-> !o_too_long)
        else $error("match result flagged as too long");

    a_miss_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_found) |-> (o_start_pos == '0) && (o_end_pos == '0))
        else $error("not-found result carries positions");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty && $stable(o_found) && $stable(o_end_pos))
        else $error("waiting result changed before pop");

endmodule
